FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AIP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define AIP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define AIP_ASSERT(name, prop, msg)
`define AIP_ASSERT_NEXT(name, pre, post, msg)
`endif
`endif

FILE: src/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Types and character constants of the ASCII integer parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package aip_pkg;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_F  = 8'h46;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  typedef enum logic [2:0] {
    PH_SPACE = 3'd0,
    PH_SIGN  = 3'd1,
    PH_ZERO  = 3'd2,
    PH_DEC   = 3'd3,
    PH_HEX   = 3'd4,
    PH_DONE  = 3'd5
  } phase_e;

  typedef struct packed {
    phase_e      phase;
    logic        negative;
    logic [63:0] acc;
    logic [63:0] nacc;
  } state_t;

  localparam state_t STATE_RESET = '{phase: PH_SPACE, negative: 1'b0,
                                     acc: 64'd0, nacc: 64'd0};

  typedef struct packed {
    logic [7:0] ch;
    logic       start_req;
  } in_beat_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               done_res;
  } out_beat_t;

endpackage
`default_nettype wire

FILE: src/aip_stream_if.sv
// ----------------------------------------------------------------------------
// aip_stream_if
// Valid/ready stream channel carrying one payload beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface aip_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: src/aip_step.sv
// ----------------------------------------------------------------------------
// aip_step
// Next-state logic for one character: phase, sign and both accumulators.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module aip_step (
  input  aip_pkg::state_t cur_i,
  input  logic [7:0]      ch_i,
  input  logic            start_req_i,
  output aip_pkg::state_t nxt_o
);
  import aip_pkg::*;

  state_t      eff;
  logic        is_space;
  logic        is_digit;
  logic        is_hex;
  logic [3:0]  dig_val;
  logic [3:0]  hex_val;
  logic [63:0] dec_acc;
  logic [63:0] dec_nacc;
  logic [63:0] hex_acc;
  logic [63:0] hex_nacc;

  assign eff = start_req_i ? STATE_RESET : cur_i;

  always_comb begin
    is_space = (ch_i == CH_SPACE) || (ch_i inside {[CH_TAB:CH_CR]});
    is_digit = ch_i inside {[CH_ZERO:CH_NINE]};
    dig_val  = 4'(ch_i - CH_ZERO);
    is_hex   = 1'b1;
    if (is_digit) begin
      hex_val = dig_val;
    end else if (ch_i inside {[CH_LC_A:CH_LC_F]}) begin
      hex_val = 4'(ch_i - CH_LC_A + 8'd10);
    end else if (ch_i inside {[CH_UC_A:CH_UC_F]}) begin
      hex_val = 4'(ch_i - CH_UC_A + 8'd10);
    end else begin
      hex_val = 4'd0;
      is_hex  = 1'b0;
    end
  end

  assign dec_acc  = (eff.acc << 3) + (eff.acc << 1) + {60'd0, dig_val};
  assign dec_nacc = (eff.nacc << 3) + (eff.nacc << 1) - {60'd0, dig_val};
  assign hex_acc  = (eff.acc << 4) + {60'd0, hex_val};
  assign hex_nacc = (eff.nacc << 4) - {60'd0, hex_val};

  always_comb begin
    nxt_o = eff;
    case (eff.phase)
      PH_SPACE: begin
        if (is_space) begin
          nxt_o.phase = PH_SPACE;
        end else if (ch_i == CH_MINUS) begin
          nxt_o.negative = 1'b1;
          nxt_o.phase    = PH_SIGN;
        end else if (ch_i == CH_PLUS) begin
          nxt_o.phase = PH_SIGN;
        end else if (ch_i == CH_ZERO) begin
          nxt_o.phase = PH_ZERO;
        end else if (is_digit) begin
          nxt_o.acc   = dec_acc;
          nxt_o.nacc  = dec_nacc;
          nxt_o.phase = PH_DEC;
        end else begin
          nxt_o.phase = PH_DONE;
        end
      end
      PH_SIGN: begin
        if (ch_i == CH_ZERO) begin
          nxt_o.phase = PH_ZERO;
        end else if (is_digit) begin
          nxt_o.acc   = dec_acc;
          nxt_o.nacc  = dec_nacc;
          nxt_o.phase = PH_DEC;
        end else begin
          nxt_o.phase = PH_DONE;
        end
      end
      PH_ZERO: begin
        if (ch_i == CH_LC_X || ch_i == CH_UC_X) begin
          nxt_o.phase = PH_HEX;
        end else if (is_digit) begin
          nxt_o.acc   = dec_acc;
          nxt_o.nacc  = dec_nacc;
          nxt_o.phase = PH_DEC;
        end else begin
          nxt_o.phase = PH_DONE;
        end
      end
      PH_DEC: begin
        if (is_digit) begin
          nxt_o.acc  = dec_acc;
          nxt_o.nacc = dec_nacc;
        end else begin
          nxt_o.phase = PH_DONE;
        end
      end
      PH_HEX: begin
        if (is_hex) begin
          nxt_o.acc  = hex_acc;
          nxt_o.nacc = hex_nacc;
        end else begin
          nxt_o.phase = PH_DONE;
        end
      end
      default: begin
        nxt_o.phase = PH_DONE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/aip_obuf.sv
// ----------------------------------------------------------------------------
// aip_obuf
// Output register with one skid entry; takes one more input beat during a stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module aip_obuf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  aip_pkg::out_beat_t  data_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                ready_i,
  output aip_pkg::out_beat_t  data_o
);
  import aip_pkg::*;

  logic      out_valid_q;
  logic      skid_valid_q;
  out_beat_t out_data_q;
  out_beat_t skid_data_q;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || ready_i) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (ready_i) begin
        out_data_q <= skid_data_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || ready_i) begin
        out_data_q <= data_i;
      end else begin
        skid_data_q <= data_i;
      end
    end
  end

  `AIP_ASSERT(a_skid_behind_out, !skid_valid_q || out_valid_q, "skid beat without output beat")
  `AIP_ASSERT_NEXT(a_push_shows, push_i, out_valid_q, "pushed beat not presented")

endmodule
`default_nettype wire

FILE: src/ascii_integer_parser_unit.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser_unit
// Streaming ASCII integer parser, one character per beat.
//
// in_i carries one character (ch) and start_req, which marks the first
// character of a new string. Every accepted input beat yields exactly one
// output beat on out_o: the signed value parsed so far (wrapped to 64 bits)
// and done_res, set once parsing has stopped.
// The result of an accepted beat is registered: it is loaded into the output
// register, or into the skid entry while the receiver stalls, as st_q updates.
// Throughput is one character per cycle while in_i.ready is high; the parser
// state and the output register (or skid entry) update in the accepting cycle,
// with a decimal or hex shift-and-add of the 64-bit accumulators in between.
// Reset puts the parser in the leading-whitespace state with a zero value,
// the same state that start_req selects, and empties the output side.
// When the receiver stalls, one further beat is taken into a skid entry;
// after that in_i.ready drops until the output beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module ascii_integer_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  aip_stream_if.sink   in_i,
  aip_stream_if.source out_o
);
  import aip_pkg::*;

  state_t    st_q;
  state_t    st_d;
  out_beat_t res;
  logic      in_fire;
  logic      obuf_ready;

  assign in_i.ready = obuf_ready;
  assign in_fire    = in_i.valid && obuf_ready;

  aip_step u_step (
    .cur_i       (st_q),
    .ch_i        (in_i.data.ch),
    .start_req_i (in_i.data.start_req),
    .nxt_o       (st_d)
  );

  assign res.value    = st_d.negative ? st_d.nacc : st_d.acc;
  assign res.done_res = (st_d.phase == PH_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= STATE_RESET;
    end else if (in_fire) begin
      st_q <= st_d;
    end
  end

  aip_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_fire),
    .data_i  (res),
    .ready_o (obuf_ready),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (out_o.data)
  );

  `AIP_ASSERT(a_acc_pair, (st_q.acc + st_q.nacc) == 64'd0, "accumulator pair out of step")
  `AIP_ASSERT_NEXT(a_done_holds, in_fire && !in_i.data.start_req && st_q.phase == PH_DONE,
                   st_q.phase == PH_DONE, "done state left without start")

endmodule
`default_nettype wire

FILE: test/ascii_integer_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser_unit_tb
// Feeds character beats to the parser and checks every output beat against
// a behavioral model of the parsing state machine kept in a scoreboard.
// A directed string set covers whitespace, signs, hex prefixes of both cases,
// the empty hex prefix, whitespace after a sign, characters after done and
// input before any start request. Random strings follow, mostly well formed
// with long digit runs that wrap the accumulator, mixed with raw byte noise.
// Both sides of the handshake idle at random, with bursts of no idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ascii_integer_parser_unit_tb;
  import aip_pkg::*;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam int unsigned CHAR_TARGET = 1100;

  class parse_scoreboard;
    phase_e      ph;
    logic        neg;
    logic [63:0] acc;
    out_beat_t   want_q[$];
    int          errors;
    int          checked;
    int          done_seen;

    function new();
      clear();
      errors    = 0;
      checked   = 0;
      done_seen = 0;
    endfunction

    function void clear();
      ph  = PH_SPACE;
      neg = 1'b0;
      acc = 64'd0;
    endfunction

    function bit is_ws(logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function bit is_dec(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function logic [4:0] hex_nibble(logic [7:0] c);
      if (is_dec(c)) return 5'(c - CH_ZERO);
      if (c >= CH_LC_A && c <= CH_LC_F) return 5'(c - CH_LC_A + 8'd10);
      if (c >= CH_UC_A && c <= CH_UC_F) return 5'(c - CH_UC_A + 8'd10);
      return 5'd16;
    endfunction

    function void take_dec(logic [7:0] c);
      if (is_dec(c)) begin
        acc = acc * 64'd10 + 64'(c - CH_ZERO);
        ph  = PH_DEC;
      end else begin
        ph = PH_DONE;
      end
    endfunction

    function void take_first(logic [7:0] c);
      if (c == CH_ZERO) ph = PH_ZERO;
      else take_dec(c);
    endfunction

    function void note_char(in_beat_t b);
      logic [4:0] h;
      out_beat_t  r;
      if (b.start_req) clear();
      case (ph)
        PH_SPACE: begin
          if (is_ws(b.ch)) begin
          end else if (b.ch == CH_MINUS) begin
            neg = 1'b1;
            ph  = PH_SIGN;
          end else if (b.ch == CH_PLUS) begin
            ph = PH_SIGN;
          end else begin
            take_first(b.ch);
          end
        end
        PH_SIGN: take_first(b.ch);
        PH_ZERO: begin
          if (b.ch == CH_LC_X || b.ch == CH_UC_X) ph = PH_HEX;
          else take_dec(b.ch);
        end
        PH_DEC: take_dec(b.ch);
        PH_HEX: begin
          h = hex_nibble(b.ch);
          if (h < 5'd16) acc = (acc << 4) + 64'(h);
          else ph = PH_DONE;
        end
        default: ph = PH_DONE;
      endcase
      r.value    = neg ? 64'd0 - acc : acc;
      r.done_res = (ph == PH_DONE);
      want_q.push_back(r);
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t w;
      if (want_q.size() == 0) begin
        $display("%0t: unexpected beat value %0d done %0b", $time, got.value, got.done_res);
        errors++;
        return;
      end
      w = want_q.pop_front();
      checked++;
      if (got.done_res) done_seen++;
      if (got.value !== w.value) begin
        $display("%0t: value expected %0d got %0d", $time, w.value, got.value);
        errors++;
      end
      if (got.done_res !== w.done_res) begin
        $display("%0t: done_res expected %0b got %0b", $time, w.done_res, got.done_res);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  aip_stream_if #(.T(in_beat_t))  in_if ();
  aip_stream_if #(.T(out_beat_t)) out_if ();

  ascii_integer_parser_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  parse_scoreboard sb = new();
  int unsigned     chars_sent;
  int unsigned     strings_sent;
  int unsigned     hex_strings;
  bit              src_burst;
  bit              snk_burst;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic int draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic push_char(input logic [7:0] c, input logic s);
    int gap;
    gap = draw_wait(src_burst);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= '{ch: c, start_req: s};
    forever begin
      @(posedge clk_i);
      if (in_if.valid && in_if.ready) break;
    end
    sb.note_char(in_if.data);
    chars_sent++;
    if (s) strings_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] ws_char();
    int k;
    k = $urandom_range(0, 5);
    return (k == 5) ? CH_SPACE : 8'(CH_TAB + k);
  endfunction

  function automatic logic [7:0] hex_char();
    int d;
    d = $urandom_range(0, 15);
    if (d < 10) return 8'(CH_ZERO + d);
    if ($urandom_range(0, 1) != 0) return 8'(CH_LC_A + d - 10);
    return 8'(CH_UC_A + d - 10);
  endfunction

  task automatic push_number();
    int  n;
    bit  first;
    first = 1'b1;
    n = $urandom_range(0, 3);
    repeat (n) begin
      push_char(ws_char(), first);
      first = 1'b0;
    end
    case ($urandom_range(0, 3))
      0: begin
        push_char(CH_MINUS, first);
        first = 1'b0;
      end
      1: begin
        push_char(CH_PLUS, first);
        first = 1'b0;
      end
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      push_char($urandom_range(0, 1) ? ws_char() : CH_MINUS, first);
      first = 1'b0;
    end
    if ($urandom_range(0, 2) == 0) begin
      hex_strings++;
      push_char(CH_ZERO, first);
      push_char($urandom_range(0, 1) ? CH_LC_X : CH_UC_X, 1'b0);
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 20);
      repeat (n) push_char(hex_char(), 1'b0);
    end else begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(19, 25) : $urandom_range(1, 8);
      repeat (n) begin
        push_char(8'(CH_ZERO + $urandom_range(0, 9)), first);
        first = 1'b0;
      end
    end
    push_char($urandom_range(0, 4) < 2 ? CH_NUL : 8'($urandom_range(0, 255)), 1'b0);
    n = $urandom_range(0, 3);
    repeat (n) push_char(8'($urandom_range(0, 255)), 1'b0);
  endtask

  task automatic push_noise();
    int n;
    n = $urandom_range(1, 8);
    push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    repeat (n - 1) push_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
  endtask

  initial begin
    int gap;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) snk_burst = ~snk_burst;
      gap = draw_wait(snk_burst);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      forever begin
        @(posedge clk_i);
        if (out_if.valid && out_if.ready) break;
      end
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_beat(out_if.data);
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    rst_ni       = 1'b0;
    chars_sent   = 0;
    strings_sent = 0;
    hex_strings  = 0;
    src_burst    = 1'b0;
    snk_burst    = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // characters ahead of any start request
    push_char(8'(CH_ZERO + 4), 1'b0);
    push_char(8'(CH_ZERO + 2), 1'b0);
    push_char(CH_NUL, 1'b0);
    // whitespace, minus, lower x, hex digits of both cases, non-hex end
    push_char(CH_TAB, 1'b1);
    push_char(CH_CR, 1'b0);
    push_char(CH_MINUS, 1'b0);
    push_char(CH_ZERO, 1'b0);
    push_char(CH_LC_X, 1'b0);
    push_char(CH_UC_F, 1'b0);
    push_char(CH_LC_F, 1'b0);
    push_char(CH_UC_A, 1'b0);
    push_char(CH_LC_A, 1'b0);
    push_char(8'(CH_LC_F + 1), 1'b0);
    // empty hex prefix, then a digit after done
    push_char(CH_PLUS, 1'b1);
    push_char(CH_ZERO, 1'b0);
    push_char(CH_UC_X, 1'b0);
    push_char(CH_NUL, 1'b0);
    push_char(8'(CH_ZERO + 5), 1'b0);
    // whitespace after sign
    push_char(CH_MINUS, 1'b1);
    push_char(CH_SPACE, 1'b0);
    // leading zero into decimal, top byte ends it
    push_char(CH_ZERO, 1'b1);
    push_char(CH_NINE, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(8'hFF, 1'b1);

    while (chars_sent < CHAR_TARGET) begin
      src_burst = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 6) == 0) push_noise();
      else push_number();
    end
    in_if.valid <= 1'b0;

    while (sb.want_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Covered %0d characters over %0d started strings, %0d with a hex prefix.",
             chars_sent, strings_sent, hex_strings);
    $display("Checked %0d result beats, %0d of them with parsing done.",
             sb.checked, sb.done_seen);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/aip_pkg.sv
src/aip_stream_if.sv
src/aip_step.sv
src/aip_obuf.sv
src/ascii_integer_parser_unit.sv
test/ascii_integer_parser_unit_tb.sv
